// ===== design/devicetree_structure_parser_core_defines.svh =====
// Assertion macros for the devicetree structure parser.
`ifndef DEVICETREE_STRUCTURE_PARSER_CORE_DEFINES_SVH
`define DEVICETREE_STRUCTURE_PARSER_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define DTSP_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("dtsp same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define DTSP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("dtsp next-cycle check failed");

`endif

// ===== design/dtsp_pkg.sv =====
// Shared types and constants for the devicetree structure parser.
`default_nettype none

package dtsp_pkg;

    localparam logic [31:0] FDT_MAGIC      = 32'hd00dfeed;
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    localparam logic [31:0] HDR_OFF_MAGIC   = 32'd0;
    localparam logic [31:0] HDR_OFF_STRUCT  = 32'd8;
    localparam logic [31:0] HDR_OFF_STRINGS = 32'd12;
    localparam logic [31:0] HDR_OFF_SIZE    = 32'd36;
    localparam logic [31:0] WORD_BYTES      = 32'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_WAIT,
        PH_TOKEN,
        PH_NAME,
        PH_AFTER,
        PH_PLEN,
        PH_POFF,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        EV_PROPERTY,
        EV_BAD_MAGIC,
        EV_BAD_TOKEN,
        EV_STRUCT_END
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [31:0] node_name_offset;
        logic [31:0] str_name_offset;
        logic [31:0] value_offset;
        logic [31:0] value_length;
    } event_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] blob_word;
        logic        last_word;
    } word_t;

endpackage

`default_nettype wire

// ===== design/dtsp_in_stage.sv =====
// Input register stage for blob words.
`default_nettype none

module dtsp_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [31:0]    in_word,
    input  wire logic           in_last,
    input  wire logic           take,
    output dtsp_pkg::word_t     held
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic        load;

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= in_word;
            last_reg <= in_last;
        end
    end

    assign held.valid     = valid_reg;
    assign held.blob_word = word_reg;
    assign held.last_word = last_reg;

endmodule

`default_nettype wire

// ===== design/dtsp_walker.sv =====
// Header capture and token walk state, one blob word per step.
`default_nettype none

module dtsp_walker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [31:0]    word,
    input  wire logic           last,
    output dtsp_pkg::event_t    ev
);

    logic [31:0]      bp_reg, bp_next;
    dtsp_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      struct_start_reg, struct_start_next;
    logic [31:0]      strings_start_reg, strings_start_next;
    logic [31:0]      struct_end_reg, struct_end_next;
    logic [31:0]      node_name_reg, node_name_next;
    logic [31:0]      pending_len_reg, pending_len_next;
    logic [29:0]      words_left_reg, words_left_next;
    logic             halted_reg, halted_next;
    logic             top_token;
    logic             zero_byte;
    logic [31:0]      len_round;
    logic [29:0]      words_dec;

    always_comb
    begin
        zero_byte = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (word[i*8 +: 8] == 8'd0)
            begin
                zero_byte = 1'b1;
            end
        end
    end

    assign len_round = pending_len_reg + 32'd3;
    assign words_dec = words_left_reg - 30'd1;

    always_comb
    begin
        top_token = 1'b0;
        if (!halted_reg)
        begin
            unique case (phase_reg)
                dtsp_pkg::PH_WAIT:
                begin
                    top_token = (bp_reg >= struct_start_reg);
                end
                dtsp_pkg::PH_TOKEN:
                begin
                    top_token = 1'b1;
                end
                dtsp_pkg::PH_AFTER:
                begin
                    top_token = (word != dtsp_pkg::TOK_PROP);
                end
                default:
                begin
                    top_token = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        bp_next            = bp_reg + dtsp_pkg::WORD_BYTES;
        phase_next         = phase_reg;
        struct_start_next  = struct_start_reg;
        strings_start_next = strings_start_reg;
        struct_end_next    = struct_end_reg;
        node_name_next     = node_name_reg;
        pending_len_next   = pending_len_reg;
        words_left_next    = words_left_reg;
        halted_next        = halted_reg;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                dtsp_pkg::PH_HEADER:
                begin
                    if (bp_reg == dtsp_pkg::HDR_OFF_MAGIC)
                    begin
                        if (word != dtsp_pkg::FDT_MAGIC)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    else if (bp_reg == dtsp_pkg::HDR_OFF_STRUCT)
                    begin
                        struct_start_next = word;
                    end
                    else if (bp_reg == dtsp_pkg::HDR_OFF_STRINGS)
                    begin
                        strings_start_next = word;
                    end
                    else if (bp_reg == dtsp_pkg::HDR_OFF_SIZE)
                    begin
                        struct_end_next = struct_start_reg + word;
                        phase_next      = dtsp_pkg::PH_WAIT;
                    end
                end
                dtsp_pkg::PH_WAIT:
                begin
                    if (bp_reg >= struct_start_reg)
                    begin
                        phase_next = dtsp_pkg::PH_TOKEN;
                    end
                end
                dtsp_pkg::PH_TOKEN:
                begin
                    phase_next = dtsp_pkg::PH_TOKEN;
                end
                dtsp_pkg::PH_NAME:
                begin
                    if (zero_byte)
                    begin
                        phase_next = dtsp_pkg::PH_AFTER;
                    end
                end
                dtsp_pkg::PH_AFTER:
                begin
                    if (word == dtsp_pkg::TOK_PROP)
                    begin
                        phase_next = dtsp_pkg::PH_PLEN;
                    end
                end
                dtsp_pkg::PH_PLEN:
                begin
                    pending_len_next = word;
                    phase_next       = dtsp_pkg::PH_POFF;
                end
                dtsp_pkg::PH_POFF:
                begin
                    words_left_next = len_round[31:2];
                    phase_next      = (len_round[31:2] != 30'd0) ?
                                      dtsp_pkg::PH_VALUE : dtsp_pkg::PH_AFTER;
                end
                dtsp_pkg::PH_VALUE:
                begin
                    words_left_next = words_dec;
                    if (words_dec == 30'd0)
                    begin
                        phase_next = dtsp_pkg::PH_AFTER;
                    end
                end
                default:
                begin
                    halted_next = 1'b1;
                end
            endcase

            if (top_token)
            begin
                if (!(bp_reg < struct_end_reg))
                begin
                    halted_next = 1'b1;
                end
                else if (word == dtsp_pkg::TOK_BEGIN_NODE)
                begin
                    node_name_next = bp_reg + dtsp_pkg::WORD_BYTES;
                    phase_next     = dtsp_pkg::PH_NAME;
                end
                else if (word == dtsp_pkg::TOK_END_NODE || word == dtsp_pkg::TOK_NOP)
                begin
                    phase_next = dtsp_pkg::PH_TOKEN;
                end
                else
                begin
                    halted_next = 1'b1;
                end
            end
        end

        if (last)
        begin
            bp_next            = '0;
            phase_next         = dtsp_pkg::PH_HEADER;
            struct_start_next  = '0;
            strings_start_next = '0;
            struct_end_next    = '0;
            node_name_next     = '0;
            pending_len_next   = '0;
            words_left_next    = '0;
            halted_next        = 1'b0;
        end
    end

    always_comb
    begin
        ev      = '0;
        ev.kind = dtsp_pkg::EV_PROPERTY;
        if (!halted_reg)
        begin
            if (phase_reg == dtsp_pkg::PH_HEADER && bp_reg == dtsp_pkg::HDR_OFF_MAGIC &&
                word != dtsp_pkg::FDT_MAGIC)
            begin
                ev.valid = 1'b1;
                ev.kind  = dtsp_pkg::EV_BAD_MAGIC;
            end
            else if (phase_reg == dtsp_pkg::PH_POFF)
            begin
                ev.valid            = 1'b1;
                ev.kind             = dtsp_pkg::EV_PROPERTY;
                ev.node_name_offset = node_name_reg;
                ev.str_name_offset  = strings_start_reg + word;
                ev.value_offset     = bp_reg + dtsp_pkg::WORD_BYTES;
                ev.value_length     = pending_len_reg;
            end
            else if (top_token)
            begin
                if (!(bp_reg < struct_end_reg))
                begin
                    ev.valid = 1'b1;
                    ev.kind  = dtsp_pkg::EV_STRUCT_END;
                end
                else if (word != dtsp_pkg::TOK_BEGIN_NODE &&
                         word != dtsp_pkg::TOK_END_NODE && word != dtsp_pkg::TOK_NOP)
                begin
                    ev.valid = 1'b1;
                    ev.kind  = (word == dtsp_pkg::TOK_END) ?
                               dtsp_pkg::EV_STRUCT_END : dtsp_pkg::EV_BAD_TOKEN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg            <= '0;
            phase_reg         <= dtsp_pkg::PH_HEADER;
            struct_start_reg  <= '0;
            strings_start_reg <= '0;
            struct_end_reg    <= '0;
            node_name_reg     <= '0;
            pending_len_reg   <= '0;
            words_left_reg    <= '0;
            halted_reg        <= 1'b0;
        end
        else if (step)
        begin
            bp_reg            <= bp_next;
            phase_reg         <= phase_next;
            struct_start_reg  <= struct_start_next;
            strings_start_reg <= strings_start_next;
            struct_end_reg    <= struct_end_next;
            node_name_reg     <= node_name_next;
            pending_len_reg   <= pending_len_next;
            words_left_reg    <= words_left_next;
            halted_reg        <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dtsp_out_stage.sv =====
// Result register stage for parser events.
`default_nettype none

module dtsp_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire dtsp_pkg::event_t ev,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_kind,
    output logic [127:0]          out_data
);

    logic                  valid_reg;
    logic                  valid_next;
    dtsp_pkg::event_kind_t kind_reg;
    logic [127:0]          data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= ev.kind;
            data_reg <= {ev.value_length, ev.value_offset,
                         ev.str_name_offset, ev.node_name_offset};
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/devicetree_structure_parser_core.sv =====
// Top level of the flattened devicetree structure block parser.
//
//  channel  | dir | tdata                                     | tuser      | tlast
//  s_axis   | in  | blob_word[31:0]                           | -          | last_word
//  m_axis   | out | node_name, str_name, value_off, value_len | event_kind | -
//
// One blob word per cycle sustained while m_axis does not stall; a word is held in
// the input register, then its event is presented from the result register.
// The walker state advances only when the result register is free or drained.
// Reset clears the walk state to the header phase; a word with tlast does the same.
// A stalled m_axis holds the event and back-pressures s_axis after one word.
`default_nettype none
`include "devicetree_structure_parser_core_defines.svh"

module devicetree_structure_parser_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [31:0]    s_axis_tdata,   // blob_word[31:0]
    input  wire logic           s_axis_tlast,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [127:0]        m_axis_tdata,   // node_name_offset[31:0],
                                                // str_name_offset[63:32],
                                                // value_offset[95:64],
                                                // value_length[127:96]
    output logic [1:0]          m_axis_tuser    // event_kind[1:0]
);

    dtsp_pkg::word_t  held;
    dtsp_pkg::event_t ev;
    logic             advance;
    logic             out_load;

    assign advance  = held.valid && (!m_axis_tvalid || m_axis_tready);
    assign out_load = advance && ev.valid;

    dtsp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .take     (advance),
        .held     (held)
    );

    dtsp_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .word  (held.blob_word),
        .last  (held.last_word),
        .ev    (ev)
    );

    dtsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .ev        (ev),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

    `DTSP_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_load, (!m_axis_tvalid || m_axis_tready))
    `DTSP_ASSERT_SAME(a_ready_low_only_full, clk, rst_n, !s_axis_tready, held.valid)
    `DTSP_ASSERT_NEXT(a_word_kept, clk, rst_n, (held.valid && !advance), held.valid)

endmodule

`default_nettype wire

// ===== tb/dtsp_event_checker.sv =====
`timescale 1ns / 1ps
// Event checker for the devicetree structure parser: predicts and compares events.
module dtsp_event_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           error_count,
    output int           pending_events
);

    typedef struct packed {
        dtsp_pkg::event_kind_t kind;
        logic [31:0]           node_name;
        logic [31:0]           str_name;
        logic [31:0]           value_off;
        logic [31:0]           value_len;
    } dt_event_t;

    dt_event_t        expected_events[$];
    dt_event_t        want;
    dtsp_pkg::phase_t phase;
    logic [31:0]      byte_pos;
    logic [31:0]      struct_base;
    logic [31:0]      strings_base;
    logic [31:0]      struct_limit;
    logic [31:0]      node_name_off;
    logic [31:0]      prop_len;
    logic [29:0]      value_left;
    logic             walk_halted;

    task automatic clear_walk();
        byte_pos      = '0;
        phase         = dtsp_pkg::PH_HEADER;
        struct_base   = '0;
        strings_base  = '0;
        struct_limit  = '0;
        node_name_off = '0;
        prop_len      = '0;
        value_left    = '0;
        walk_halted   = 1'b0;
    endtask

    task automatic note_event(input dtsp_pkg::event_kind_t kind, input logic [31:0] node,
                              input logic [31:0] sname, input logic [31:0] voff,
                              input logic [31:0] vlen);
        expected_events.push_back('{kind, node, sname, voff, vlen});
    endtask

    task automatic top_token(input logic [31:0] w, input logic [31:0] bp);
        if (bp >= struct_limit)
        begin
            note_event(dtsp_pkg::EV_STRUCT_END, '0, '0, '0, '0);
            walk_halted = 1'b1;
        end
        else if (w == dtsp_pkg::TOK_BEGIN_NODE)
        begin
            node_name_off = bp + dtsp_pkg::WORD_BYTES;
            phase         = dtsp_pkg::PH_NAME;
        end
        else if (w == dtsp_pkg::TOK_END_NODE || w == dtsp_pkg::TOK_NOP)
        begin
            phase = dtsp_pkg::PH_TOKEN;
        end
        else
        begin
            note_event((w == dtsp_pkg::TOK_END) ? dtsp_pkg::EV_STRUCT_END :
                       dtsp_pkg::EV_BAD_TOKEN, '0, '0, '0, '0);
            walk_halted = 1'b1;
        end
    endtask

    task automatic walk_word(input logic [31:0] w, input logic lst);
        logic [31:0] bp;
        logic [31:0] rounded;
        bp = byte_pos;
        if (!walk_halted)
        begin
            case (phase)
                dtsp_pkg::PH_HEADER:
                begin
                    if (bp == dtsp_pkg::HDR_OFF_MAGIC)
                    begin
                        if (w != dtsp_pkg::FDT_MAGIC)
                        begin
                            note_event(dtsp_pkg::EV_BAD_MAGIC, '0, '0, '0, '0);
                            walk_halted = 1'b1;
                        end
                    end
                    else if (bp == dtsp_pkg::HDR_OFF_STRUCT)
                        struct_base = w;
                    else if (bp == dtsp_pkg::HDR_OFF_STRINGS)
                        strings_base = w;
                    else if (bp == dtsp_pkg::HDR_OFF_SIZE)
                    begin
                        struct_limit = struct_base + w;
                        phase        = dtsp_pkg::PH_WAIT;
                    end
                end
                dtsp_pkg::PH_WAIT:
                begin
                    if (bp >= struct_base)
                    begin
                        phase = dtsp_pkg::PH_TOKEN;
                        top_token(w, bp);
                    end
                end
                dtsp_pkg::PH_TOKEN:
                    top_token(w, bp);
                dtsp_pkg::PH_NAME:
                begin
                    if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                        w[15:8] == 8'h00 || w[7:0] == 8'h00)
                        phase = dtsp_pkg::PH_AFTER;
                end
                dtsp_pkg::PH_AFTER:
                begin
                    if (w == dtsp_pkg::TOK_PROP)
                        phase = dtsp_pkg::PH_PLEN;
                    else
                        top_token(w, bp);
                end
                dtsp_pkg::PH_PLEN:
                begin
                    prop_len = w;
                    phase    = dtsp_pkg::PH_POFF;
                end
                dtsp_pkg::PH_POFF:
                begin
                    note_event(dtsp_pkg::EV_PROPERTY, node_name_off, strings_base + w,
                               bp + dtsp_pkg::WORD_BYTES, prop_len);
                    rounded    = prop_len + 32'd3;
                    value_left = rounded[31:2];
                    phase      = (value_left != '0) ? dtsp_pkg::PH_VALUE : dtsp_pkg::PH_AFTER;
                end
                dtsp_pkg::PH_VALUE:
                begin
                    value_left = value_left - 30'd1;
                    if (value_left == '0)
                        phase = dtsp_pkg::PH_AFTER;
                end
                default:
                    walk_halted = 1'b1;
            endcase
        end
        byte_pos = bp + dtsp_pkg::WORD_BYTES;
        if (lst)
            clear_walk();
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_val,
                               input logic [31:0] actual_val);
        if (expected_val !== actual_val)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, name, expected_val, actual_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_walk();
            expected_events.delete();
            error_count    = 0;
            pending_events = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected event: expected none, actual kind %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("node_name_offset", want.node_name, m_axis_tdata[31:0]);
                    check_field("str_name_offset", want.str_name, m_axis_tdata[63:32]);
                    check_field("value_offset", want.value_off, m_axis_tdata[95:64]);
                    check_field("value_length", want.value_len, m_axis_tdata[127:96]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                walk_word(s_axis_tdata, s_axis_tlast);
            pending_events = expected_events.size();
        end
    end

endmodule

// ===== tb/devicetree_structure_parser_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the devicetree structure parser: blob stimulus, flow control and verdict.
module devicetree_structure_parser_core_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int WORDS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES    = 20;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    int          error_count;
    int          pending_events;
    int          src_idle_pct = 13;
    int          dst_idle_pct = 88;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          target;
    logic [31:0] blob_words[$];
    logic [31:0] body_words[$];

    devicetree_structure_parser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dtsp_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .error_count    (error_count),
        .pending_events (pending_events)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_word(input logic [31:0] w, input logic lst);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_blob();
        foreach (blob_words[i])
            send_word(blob_words[i], i == blob_words.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_events != 0);
    endtask

    function automatic logic [31:0] name_word(input bit terminal);
        logic [31:0] w;
        int          b;
        int          pos;
        for (b = 0; b < 4; b++)
            w[8*b +: 8] = 8'($urandom_range(1, 255));
        if (terminal)
        begin
            pos = $urandom_range(0, 3);
            w[8*pos +: 8] = 8'h00;
            if ($urandom_range(0, 7) == 0)
                w = '0;
        end
        return w;
    endfunction

    task automatic add_property();
        logic [31:0] len;
        logic [31:0] rounded;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            len = $urandom_range(0, 12);
        else if (pick < 95)
            len = 32'hffff_fffc + 32'($urandom_range(1, 3));
        else
            len = $urandom_range(13, 40);
        body_words.push_back(dtsp_pkg::TOK_PROP);
        body_words.push_back(len);
        body_words.push_back($urandom);
        rounded = len + 32'd3;
        repeat (int'(rounded[31:2]))
            body_words.push_back($urandom);
    endtask

    task automatic add_node(input int depth);
        body_words.push_back(dtsp_pkg::TOK_BEGIN_NODE);
        repeat ($urandom_range(0, 2))
            body_words.push_back(name_word(1'b0));
        body_words.push_back(name_word(1'b1));
        repeat ($urandom_range(0, 3))
            add_property();
        if (depth < 2 && $urandom_range(0, 2) == 0)
            add_node(depth + 1);
        if ($urandom_range(0, 9) == 0)
            body_words.push_back(dtsp_pkg::TOK_NOP);
        body_words.push_back(dtsp_pkg::TOK_END_NODE);
    endtask

    task automatic make_blob();
        logic [31:0] struct_off;
        logic [31:0] size_field;
        logic [31:0] body_bytes;
        int          pad;
        int          pick;
        int          cut;
        blob_words.delete();
        body_words.delete();

        pick = $urandom_range(0, 99);
        if (pick < 70)
            struct_off = 40 + 4 * $urandom_range(0, 3);
        else if (pick < 80)
            struct_off = $urandom_range(0, 39);
        else if (pick < 92)
            struct_off = $urandom_range(41, 56);
        else
            struct_off = $urandom;
        if (struct_off <= 40)
            pad = 0;
        else if (struct_off <= 72)
            pad = (int'(struct_off) - 40 + 3) / 4;
        else
            pad = -1;

        pick = $urandom_range(0, 99);
        if (pad < 0)
        begin
            repeat (3)
                body_words.push_back($urandom);
        end
        else if (pick < 4)
        begin
            // huge property length, blob cut inside the value
            body_words.push_back(dtsp_pkg::TOK_BEGIN_NODE);
            body_words.push_back(name_word(1'b1));
            body_words.push_back(dtsp_pkg::TOK_PROP);
            body_words.push_back(32'h8000_0000 | $urandom);
            body_words.push_back($urandom);
            repeat ($urandom_range(0, 4))
                body_words.push_back($urandom);
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                add_node(0);
                if ($urandom_range(0, 3) == 0)
                    body_words.push_back(dtsp_pkg::TOK_NOP);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                body_words.push_back(dtsp_pkg::TOK_PROP);
            else if (pick < 16)
                body_words.push_back($urandom);
            if (pick >= 8)
                body_words.push_back(dtsp_pkg::TOK_END);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2))
                    body_words.push_back($urandom);
        end

        body_bytes = 4 * body_words.size();
        pick = $urandom_range(0, 99);
        if (pick < 75)
            size_field = body_bytes + 4 * $urandom_range(0, 2);
        else if (pick < 92)
            size_field = $urandom_range(0, int'(body_bytes));
        else
            size_field = $urandom;

        blob_words.push_back(($urandom_range(0, 24) == 0) ? $urandom : dtsp_pkg::FDT_MAGIC);
        blob_words.push_back($urandom);
        blob_words.push_back(struct_off);
        blob_words.push_back($urandom);
        repeat (5)
            blob_words.push_back($urandom);
        blob_words.push_back(size_field);
        repeat ((pad > 0) ? pad : 0)
            blob_words.push_back($urandom);
        foreach (body_words[i])
            blob_words.push_back(body_words[i]);

        if ($urandom_range(0, 99) < 6)
        begin
            cut = $urandom_range(1, blob_words.size() - 1);
            while (blob_words.size() > cut)
                void'(blob_words.pop_back());
        end
    endtask

    initial
    begin
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bad magic, then a word that only resets
        blob_words = '{~dtsp_pkg::FDT_MAGIC, 32'hffff_ffff};
        send_blob();

        // structure offset inside the header, extreme property fields, top-level PROP
        blob_words = '{dtsp_pkg::FDT_MAGIC, 32'h0, 32'd8, 32'hffff_ffff, 32'h0, 32'h0,
                       32'h0, 32'h0, 32'h0, 32'h100,
                       dtsp_pkg::TOK_BEGIN_NODE, 32'h2f00_0000,
                       dtsp_pkg::TOK_PROP, 32'hffff_ffff, 32'hffff_ffff,
                       dtsp_pkg::TOK_PROP, 32'h0, 32'h0,
                       dtsp_pkg::TOK_END_NODE, dtsp_pkg::TOK_PROP};
        send_blob();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 13;
                    dst_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct = 88;
                    dst_idle_pct = 13;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
            begin
                make_blob();
                send_blob();
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (error_count == 0 && pending_events == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== devicetree_structure_parser_core.f =====
+incdir+design
design/dtsp_pkg.sv
design/dtsp_in_stage.sv
design/dtsp_walker.sv
design/dtsp_out_stage.sv
design/devicetree_structure_parser_core.sv
tb/dtsp_event_checker.sv
tb/devicetree_structure_parser_core_tb.sv
